/* rtl/pes_pkg.sv */
`default_nettype none

package pes_pkg;

  // Phase codes of the envelope cycle
  localparam int unsigned PHASE_W = 3;
  typedef logic [PHASE_W-1:0] phase_t;

  localparam phase_t PH_TRI_UP    = 3'd0;
  localparam phase_t PH_TRI_DOWN  = 3'd1;
  localparam phase_t PH_TRAP_UP   = 3'd2;
  localparam phase_t PH_PLATEAU   = 3'd3;
  localparam phase_t PH_TRAP_DOWN = 3'd4;
  localparam phase_t PH_SINE      = 3'd5;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 10;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  localparam cfg_idx_t CFG_RAMP_POINTS    = 3'd0;
  localparam cfg_idx_t CFG_SINE_PERIOD    = 3'd1;
  localparam cfg_idx_t CFG_SINE_STEPS     = 3'd2;
  localparam cfg_idx_t CFG_PLATEAU_LENGTH = 3'd3;
  localparam cfg_idx_t CFG_SLOW_DIVIDER   = 3'd4;

  localparam logic [7:0] RST_RAMP_POINTS    = 8'd10;
  localparam logic [7:0] RST_SINE_PERIOD    = 8'd32;
  localparam logic [5:0] RST_SINE_STEPS     = 6'd20;
  localparam logic [7:0] RST_PLATEAU_LENGTH = 8'd100;
  localparam logic [9:0] RST_SLOW_DIVIDER   = 10'd100;

  // Sine duty table; entries past the table or past the usable depth read as zero
  localparam int unsigned SINE_TABLE_DEPTH = 32;
  localparam int unsigned SINE_ROM_LEN     = 20;
  localparam logic [5:0] SINE_ROM [SINE_ROM_LEN] = '{
    6'd5,  6'd10, 6'd15, 6'd19, 6'd23, 6'd26, 6'd28, 6'd30, 6'd31, 6'd32,
    6'd31, 6'd30, 6'd28, 6'd26, 6'd23, 6'd19, 6'd15, 6'd10, 6'd5,  6'd0
  };

  // 4095 mod (6 + 2*k): where an all-empty cycle of 6 + 2*k parts lands after
  // the part search runs out, indexed by the sine step count k
  localparam int unsigned SKIP_ENTRIES = 64;
  localparam logic [6:0] EMPTY_SKIP [SKIP_ENTRIES] = '{
    7'd3,   7'd7,   7'd5,   7'd3,   7'd7,   7'd15,  7'd9,   7'd15,
    7'd3,   7'd15,  7'd13,  7'd7,   7'd15,  7'd31,  7'd15,  7'd27,
    7'd29,  7'd15,  7'd21,  7'd3,   7'd1,   7'd15,  7'd45,  7'd39,
    7'd45,  7'd7,   7'd35,  7'd15,  7'd3,   7'd63,  7'd3,   7'd15,
    7'd35,  7'd63,  7'd25,  7'd67,  7'd39,  7'd15,  7'd77,  7'd63,
    7'd53,  7'd47,  7'd45,  7'd47,  7'd53,  7'd63,  7'd77,  7'd95,
    7'd15,  7'd39,  7'd67,  7'd99,  7'd25,  7'd63,  7'd105, 7'd35,
    7'd83,  7'd15,  7'd69,  7'd3,   7'd63,  7'd127, 7'd65,  7'd3
  };

  function automatic logic [7:0] sine_at(input logic [7:0] idx);
    logic [7:0] val;
    val = '0;
    if ((32'(idx) < SINE_TABLE_DEPTH) && (32'(idx) < SINE_ROM_LEN)) begin
      val = {2'b00, SINE_ROM[idx[4:0]]};
    end
    return val;
  endfunction

endpackage

`default_nettype wire

/* rtl/pes_if.sv */
`default_nettype none

interface pes_in_if;
  logic valid;
  logic ready;
  logic advance;

  modport source (output valid, output advance, input ready);
  modport sink   (input valid, input advance, output ready);
endinterface

interface pes_out_if;
  import pes_pkg::*;

  logic   valid;
  logic   ready;
  logic   ramp_pin;
  logic   trapezoid_pin;
  logic   sine_pin;
  phase_t phase_now;

  modport source (output valid, output ramp_pin, output trapezoid_pin,
                  output sine_pin, output phase_now, input ready);
  modport sink   (input valid, input ramp_pin, input trapezoid_pin,
                  input sine_pin, input phase_now, output ready);
endinterface

`default_nettype wire

/* rtl/pwm_envelope_sequencer_top.sv */
`default_nettype none

// PWM envelope sequencer. Each request on in_chan carries one timer tick
// (advance = 1) or a hold (advance = 0) and produces exactly one request on
// out_chan with the three pin levels and the phase after that tick. The
// search for the next non-empty part of the six-phase cycle is resolved in
// closed form between the state registers and the result register, so
// requests are taken in every cycle while out_chan keeps up. The result
// register doubles as the only buffer: in_chan.ready is high whenever it is
// empty or being drained. Configuration writes on cfg_* take effect on the
// next clock and are expected only while no request is open.
module pwm_envelope_sequencer_top (
  input  logic               clk,
  input  logic               rst_n,
  pes_in_if.sink             in_chan,
  pes_out_if.source          out_chan,
  input  logic               cfg_we,
  input  pes_pkg::cfg_idx_t  cfg_index,
  input  pes_pkg::cfg_data_t cfg_data
);
  import pes_pkg::*;

  typedef struct packed {
    phase_t     ph;
    logic [7:0] idx;
    logic       hi;
  } part_t;

  // Configuration
  logic [7:0] ramp_points_r;
  logic [7:0] sine_period_r;
  logic [5:0] sine_steps_r;
  logic [7:0] plateau_length_r;
  logic [9:0] slow_divider_r;

  // Sequencer state; pins_r and phase_r also form the result register
  phase_t     phase_r,    phase_nxt;
  logic [7:0] step_r,     step_nxt;
  logic [7:0] unit_r,     unit_nxt;
  logic       high_r,     high_nxt;
  logic [9:0] prescale_r, prescale_nxt;
  logic [2:0] pins_r,     pins_nxt;
  logic       out_valid_r, out_valid_nxt;

  logic       in_fire;

  part_t      cur_part, s0_part, t_part, w_part, e_part, em_part, wrap_part;
  logic [7:0] cur_unit, s0_unit;
  logic       hit0, w_found, e_found;
  logic [7:0] hcl_t, hcl_t1, hcl_0;
  logic [7:0] wrap_pos, cyc_len, fin_pos, rel_pos;
  logic [8:0] wrap_sum;

  function automatic logic step_ok(input phase_t ph, input logic [8:0] i9,
                                   input logic [7:0] n, input logic [5:0] k);
    logic ok;
    case (ph)
      PH_TRI_UP, PH_TRAP_UP:     ok = (i9 <= {1'b0, n});
      PH_TRI_DOWN, PH_TRAP_DOWN: ok = (i9 < {1'b0, n});
      PH_PLATEAU:                ok = (i9 == 9'd0);
      default:                   ok = (i9 < {3'b000, k});
    endcase
    return ok;
  endfunction

  function automatic logic entry_ok(input phase_t ph, input logic [7:0] n,
                                    input logic [5:0] k);
    logic ok;
    case (ph)
      PH_TRI_DOWN, PH_TRAP_DOWN: ok = (n >= 8'd2);
      PH_SINE:                   ok = (k != 6'd0);
      default:                   ok = 1'b1;
    endcase
    return ok;
  endfunction

  function automatic phase_t phase_inc(input phase_t ph);
    return (ph >= PH_SINE) ? PH_TRI_UP : ph + 3'd1;
  endfunction

  // First phase after ph whose opening step exists; at most two are skipped
  function automatic phase_t next_phase(input phase_t ph, input logic [7:0] n,
                                        input logic [5:0] k);
    phase_t q1, q2;
    q1 = phase_inc(ph);
    q2 = phase_inc(q1);
    if (entry_ok(q1, n, k)) begin
      return q1;
    end else if (entry_ok(q2, n, k)) begin
      return q2;
    end
    return phase_inc(q2);
  endfunction

  function automatic logic [7:0] entry_idx(input phase_t ph);
    return ((ph == PH_TRI_DOWN) || (ph == PH_TRAP_DOWN)) ? 8'd1 : 8'd0;
  endfunction

  function automatic logic [7:0] sine_high(input logic [7:0] idx, input logic [7:0] s);
    logic [7:0] t;
    t = sine_at(idx);
    return (t > s) ? s : t;
  endfunction

  function automatic logic [7:0] part_len(input part_t p, input logic [7:0] n,
                                          input logic [7:0] s, input logic [7:0] plat);
    logic [7:0] len;
    logic [7:0] h;
    h = sine_high(p.idx, s);
    case (p.ph)
      PH_TRI_UP, PH_TRAP_UP:     len = p.hi ? p.idx : n - p.idx;
      PH_TRI_DOWN, PH_TRAP_DOWN: len = p.hi ? n - p.idx : p.idx;
      PH_PLATEAU:                len = p.hi ? plat : 8'd0;
      default:                   len = p.hi ? h : s - h;
    endcase
    return len;
  endfunction

  function automatic logic entry_hit(input phase_t ph, input logic [7:0] n,
                                     input logic [5:0] k, input logic [7:0] s,
                                     input logic [7:0] plat);
    logic hit;
    case (ph)
      PH_TRI_UP, PH_TRAP_UP:     hit = (n != 8'd0);
      PH_TRI_DOWN, PH_TRAP_DOWN: hit = (n >= 8'd2);
      PH_PLATEAU:                hit = (plat != 8'd0);
      default:                   hit = (k != 6'd0) && (s != 8'd0);
    endcase
    return hit;
  endfunction

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign in_fire       = in_chan.valid && in_chan.ready;

  assign out_chan.valid         = out_valid_r;
  assign out_chan.ramp_pin      = pins_r[0];
  assign out_chan.trapezoid_pin = pins_r[1];
  assign out_chan.sine_pin      = pins_r[2];
  assign out_chan.phase_now     = phase_r;

  // Current part, with an out-of-range phase restarting the cycle
  always_comb begin
    if (phase_r > PH_SINE) begin
      cur_part.ph  = PH_TRI_UP;
      cur_part.idx = 8'd0;
      cur_part.hi  = 1'b1;
      cur_unit     = 8'd0;
    end else begin
      cur_part.ph  = phase_r;
      cur_part.idx = step_r;
      cur_part.hi  = high_r;
      cur_unit     = unit_r;
    end
  end

  // First part examined: the current one, or one move on if its step has
  // fallen out of range (a high part then drops to its own low part)
  always_comb begin
    s0_part = cur_part;
    s0_unit = cur_unit;
    if (!step_ok(cur_part.ph, {1'b0, cur_part.idx}, ramp_points_r, sine_steps_r)) begin
      s0_unit = 8'd0;
      if (cur_part.hi) begin
        s0_part.hi = 1'b0;
      end else begin
        s0_part.ph  = next_phase(cur_part.ph, ramp_points_r, sine_steps_r);
        s0_part.idx = entry_idx(s0_part.ph);
        s0_part.hi  = 1'b1;
      end
    end
  end

  assign hit0 = s0_unit < part_len(s0_part, ramp_points_r, sine_period_r,
                                   plateau_length_r);

  // Part after s0
  always_comb begin
    t_part = s0_part;
    if (s0_part.hi) begin
      t_part.hi = 1'b0;
    end else if ((s0_part.idx != 8'hFF) &&
                 step_ok(s0_part.ph, {1'b0, s0_part.idx} + 9'd1,
                         ramp_points_r, sine_steps_r)) begin
      t_part.idx = s0_part.idx + 8'd1;
      t_part.hi  = 1'b1;
    end else begin
      t_part.ph  = next_phase(s0_part.ph, ramp_points_r, sine_steps_r);
      t_part.idx = entry_idx(t_part.ph);
      t_part.hi  = 1'b1;
    end
  end

  assign hcl_t  = sine_high(t_part.idx, sine_period_r);
  assign hcl_t1 = sine_high(t_part.idx + 8'd1, sine_period_r);
  assign hcl_0  = sine_high(8'd0, sine_period_r);

  // First non-empty part at or after t within t's phase
  always_comb begin
    w_found = 1'b0;
    w_part  = t_part;
    case (t_part.ph)
      PH_TRI_UP, PH_TRAP_UP: begin
        if (t_part.hi) begin
          if (t_part.idx != 8'd0) begin
            w_found = 1'b1;
          end else if (ramp_points_r != 8'd0) begin
            w_found   = 1'b1;
            w_part.hi = 1'b0;
          end
        end else if (t_part.idx != ramp_points_r) begin
          w_found = 1'b1;
        end
      end
      PH_TRI_DOWN, PH_TRAP_DOWN: begin
        w_found = 1'b1;
      end
      PH_PLATEAU: begin
        w_found = t_part.hi && (plateau_length_r != 8'd0);
      end
      default: begin
        if (sine_period_r != 8'd0) begin
          if (t_part.hi) begin
            w_found   = 1'b1;
            w_part.hi = (hcl_t != 8'd0);
          end else if (hcl_t != sine_period_r) begin
            w_found = 1'b1;
          end else if (({1'b0, t_part.idx} + 9'd1) < {3'b000, sine_steps_r}) begin
            w_found    = 1'b1;
            w_part.idx = t_part.idx + 8'd1;
            w_part.hi  = (hcl_t1 != 8'd0);
          end
        end
      end
    endcase
  end

  // First non-empty part of the following phases, wrapping to t's own phase
  always_comb begin
    logic [3:0] qs;
    phase_t     q;
    e_found = 1'b0;
    e_part  = t_part;
    for (int j = 6; j >= 1; j--) begin
      qs = {1'b0, t_part.ph} + 4'(j);
      if (qs >= 4'd6) begin
        qs = qs - 4'd6;
      end
      q = qs[2:0];
      if (entry_hit(q, ramp_points_r, sine_steps_r, sine_period_r, plateau_length_r)) begin
        e_found    = 1'b1;
        e_part.ph  = q;
        e_part.idx = entry_idx(q);
        case (q)
          PH_TRI_UP, PH_TRAP_UP: e_part.hi = 1'b0;
          PH_SINE:               e_part.hi = (hcl_0 != 8'd0);
          default:               e_part.hi = 1'b1;
        endcase
      end
    end
  end

  always_comb begin
    if (hit0) begin
      em_part = s0_part;
    end else if (w_found) begin
      em_part = w_part;
    end else begin
      em_part = e_part;
    end
  end

  // All-empty cycle: walk 4095 more parts from t in closed form
  always_comb begin
    case (t_part.ph)
      PH_TRI_UP:  wrap_pos = {7'd0, !t_part.hi};
      PH_TRAP_UP: wrap_pos = 8'd2 + {7'd0, !t_part.hi};
      PH_PLATEAU: wrap_pos = 8'd4 + {7'd0, !t_part.hi};
      default:    wrap_pos = 8'd6 + {t_part.idx[6:0], !t_part.hi};
    endcase
    cyc_len  = 8'd6 + {1'b0, sine_steps_r, 1'b0};
    wrap_sum = {1'b0, wrap_pos} + {2'b00, EMPTY_SKIP[sine_steps_r]};
    if (wrap_sum >= {1'b0, cyc_len}) begin
      wrap_sum = wrap_sum - {1'b0, cyc_len};
    end
    fin_pos = wrap_sum[7:0];
    rel_pos = fin_pos - 8'd6;
    wrap_part.hi = !fin_pos[0];
    if (fin_pos < 8'd6) begin
      wrap_part.idx = 8'd0;
      case (fin_pos[2:1])
        2'd0:    wrap_part.ph = PH_TRI_UP;
        2'd1:    wrap_part.ph = PH_TRAP_UP;
        default: wrap_part.ph = PH_PLATEAU;
      endcase
    end else begin
      wrap_part.ph  = PH_SINE;
      wrap_part.idx = {1'b0, rel_pos[7:1]};
    end
  end

  always_comb begin
    phase_nxt    = phase_r;
    step_nxt     = step_r;
    unit_nxt     = unit_r;
    high_nxt     = high_r;
    prescale_nxt = prescale_r;
    pins_nxt     = pins_r;
    if (in_fire && in_chan.advance) begin
      if (prescale_r != 10'd0) begin
        prescale_nxt = prescale_r - 10'd1;
      end else if (hit0 || w_found || e_found) begin
        phase_nxt = em_part.ph;
        step_nxt  = em_part.idx;
        high_nxt  = em_part.hi;
        unit_nxt  = hit0 ? s0_unit + 8'd1 : 8'd1;
        if (em_part.ph <= PH_TRI_DOWN) begin
          pins_nxt[0] = em_part.hi;
        end else if (em_part.ph <= PH_TRAP_DOWN) begin
          pins_nxt[1] = em_part.hi;
        end else begin
          pins_nxt[2] = em_part.hi;
        end
        // hold the unit for one tick in the fast phase or with a zero divider, else one slow unit
        if ((em_part.ph == PH_TRI_UP) || (slow_divider_r == 10'd0)) begin
          prescale_nxt = 10'd0;
        end else begin
          prescale_nxt = slow_divider_r - 10'd1;
        end
      end else begin
        phase_nxt = wrap_part.ph;
        step_nxt  = wrap_part.idx;
        high_nxt  = wrap_part.hi;
        unit_nxt  = 8'd0;
      end
    end
  end

  always_comb begin
    if (in_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ramp_points_r    <= RST_RAMP_POINTS;
      sine_period_r    <= RST_SINE_PERIOD;
      sine_steps_r     <= RST_SINE_STEPS;
      plateau_length_r <= RST_PLATEAU_LENGTH;
      slow_divider_r   <= RST_SLOW_DIVIDER;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RAMP_POINTS:    ramp_points_r    <= cfg_data[7:0];
        CFG_SINE_PERIOD:    sine_period_r    <= cfg_data[7:0];
        CFG_SINE_STEPS:     sine_steps_r     <= cfg_data[5:0];
        CFG_PLATEAU_LENGTH: plateau_length_r <= cfg_data[7:0];
        CFG_SLOW_DIVIDER:   slow_divider_r   <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_TRI_UP;
      step_r      <= '0;
      unit_r      <= '0;
      high_r      <= 1'b0;
      prescale_r  <= '0;
      pins_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      step_r      <= step_nxt;
      unit_r      <= unit_nxt;
      high_r      <= high_nxt;
      prescale_r  <= prescale_nxt;
      pins_r      <= pins_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

/* verif/pwm_envelope_sequencer_top_test.sv */
module pwm_envelope_sequencer_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import pes_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DUTY_LEN = 20;
  localparam logic [7:0] SINE_DUTY [DUTY_LEN] = '{
    8'd5,  8'd10, 8'd15, 8'd19, 8'd23, 8'd26, 8'd28, 8'd30, 8'd31, 8'd32,
    8'd31, 8'd30, 8'd28, 8'd26, 8'd23, 8'd19, 8'd15, 8'd10, 8'd5,  8'd0
  };

  typedef struct packed {
    logic   ramp;
    logic   trap;
    logic   sine;
    phase_t ph;
  } pin_state_t;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      cfg_we;
  cfg_idx_t  cfg_index;
  cfg_data_t cfg_data;

  pes_in_if  in_if();
  pes_out_if out_if();

  pwm_envelope_sequencer_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_if),
    .out_chan  (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // Sequencer settings as last written
  logic [7:0] pts, sine_per, plat_len;
  logic [5:0] sine_cnt;
  logic [9:0] slow_div;

  // Sequencer state
  phase_t     cur_phase;
  logic [7:0] step_idx, units_done;
  logic       in_high;
  logic [9:0] ticks_left;
  logic [2:0] pin_lvl;

  bit         tick_q[$];
  pin_state_t pin_state_q[$];
  int         ticks_queued = 0;
  int         ticks_sent = 0;
  int         mismatches = 0;
  int         idle_cycles = 0;
  bit         gaps_on = 1'b1;

  function automatic phase_t following(input phase_t p);
    return (p >= PH_SINE) ? PH_TRI_UP : phase_t'(p + 1);
  endfunction

  function automatic logic [7:0] duty_entry(input logic [7:0] idx);
    if (idx < DUTY_LEN) begin
      return SINE_DUTY[idx[4:0]];
    end
    return 8'd0;
  endfunction

  function automatic logic [7:0] part_len();
    logic [7:0] t;
    logic [7:0] h;
    logic [7:0] len;
    t = duty_entry(step_idx);
    h = (t > sine_per) ? sine_per : t;
    case (cur_phase)
      PH_TRI_UP, PH_TRAP_UP:     len = in_high ? step_idx : pts - step_idx;
      PH_TRI_DOWN, PH_TRAP_DOWN: len = in_high ? pts - step_idx : step_idx;
      PH_PLATEAU:                len = in_high ? plat_len : 8'd0;
      default:                   len = in_high ? h : sine_per - h;
    endcase
    return len;
  endfunction

  function automatic bit step_ok();
    case (cur_phase)
      PH_TRI_UP, PH_TRAP_UP:     return step_idx <= pts;
      PH_TRI_DOWN, PH_TRAP_DOWN: return step_idx < pts;
      PH_PLATEAU:                return step_idx == 8'd0;
      default:                   return step_idx < {2'b00, sine_cnt};
    endcase
  endfunction

  function automatic void enter_phase(input phase_t p);
    cur_phase  = p;
    step_idx   = (p == PH_TRI_DOWN || p == PH_TRAP_DOWN) ? 8'd1 : 8'd0;
    in_high    = 1'b1;
    units_done = 8'd0;
  endfunction

  function automatic void advance_part();
    if (in_high) begin
      in_high    = 1'b0;
      units_done = 8'd0;
      return;
    end
    if (step_idx == 8'd255) begin
      enter_phase(following(cur_phase));
    end else begin
      step_idx   = step_idx + 8'd1;
      in_high    = 1'b1;
      units_done = 8'd0;
    end
    while (!step_ok()) begin
      enter_phase(following(cur_phase));
    end
  endfunction

  // Write the next non-empty unit; give up after a bounded search
  function automatic bit emit_unit();
    int guard;
    if (!step_ok()) begin
      advance_part();
    end
    for (guard = 0; guard < 4096; guard++) begin
      if (units_done < part_len()) begin
        if (cur_phase <= PH_TRI_DOWN) begin
          pin_lvl[0] = in_high;
        end else if (cur_phase <= PH_TRAP_DOWN) begin
          pin_lvl[1] = in_high;
        end else begin
          pin_lvl[2] = in_high;
        end
        units_done = units_done + 8'd1;
        return 1'b1;
      end
      advance_part();
    end
    return 1'b0;
  endfunction

  function automatic void predict_tick(input logic advance);
    logic [9:0] dur;
    if (advance) begin
      if (ticks_left == 10'd0) begin
        if (emit_unit()) begin
          dur = (cur_phase == PH_TRI_UP) ? 10'd1 : slow_div;
          if (dur == 10'd0) begin
            dur = 10'd1;
          end
          ticks_left = dur - 10'd1;
        end
      end else begin
        ticks_left = ticks_left - 10'd1;
      end
    end
    pin_state_q.push_back('{pin_lvl[0], pin_lvl[1], pin_lvl[2], cur_phase});
  endfunction

  function automatic void apply_reg(input cfg_idx_t idx, input cfg_data_t v);
    case (idx)
      CFG_RAMP_POINTS:    pts      = v[7:0];
      CFG_SINE_PERIOD:    sine_per = v[7:0];
      CFG_SINE_STEPS:     sine_cnt = v[5:0];
      CFG_PLATEAU_LENGTH: plat_len = v[7:0];
      CFG_SLOW_DIVIDER:   slow_div = v;
      default: ;
    endcase
  endfunction

  task automatic write_reg(input cfg_idx_t idx, input cfg_data_t v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    apply_reg(idx, v);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_all(input int unsigned n, input int unsigned per, input int unsigned steps,
                         input int unsigned plat, input int unsigned div);
    write_reg(CFG_RAMP_POINTS, cfg_data_t'(n));
    write_reg(CFG_SINE_PERIOD, cfg_data_t'(per));
    write_reg(CFG_SINE_STEPS, cfg_data_t'(steps));
    write_reg(CFG_PLATEAU_LENGTH, cfg_data_t'(plat));
    write_reg(CFG_SLOW_DIVIDER, cfg_data_t'(div));
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (ticks_sent != ticks_queued || pin_state_q.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic queue_bits(input bit b, input int n);
    @(negedge clk);
    repeat (n) tick_q.push_back(b);
    ticks_queued += n;
  endtask

  task automatic queue_ticks(input int n, input int hold_pct);
    @(negedge clk);
    repeat (n) tick_q.push_back($urandom_range(0, 99) >= hold_pct);
    ticks_queued += n;
  endtask

  // Tick driver: predict on acceptance, hold the request until taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid   <= 1'b0;
      in_if.advance <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        predict_tick(in_if.advance);
        ticks_sent++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (tick_q.size() != 0 && !(gaps_on && $urandom_range(0, 99) < 22)) begin
          in_if.valid   <= 1'b1;
          in_if.advance <= tick_q.pop_front();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin : result_monitor
    pin_state_t got;
    pin_state_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got = '{out_if.ramp_pin, out_if.trapezoid_pin, out_if.sine_pin, out_if.phase_now};
        if (pin_state_q.size() == 0) begin
          if (mismatches < 10) begin
            $display("unexpected result: ramp %b trap %b sine %b phase %0d",
                     got.ramp, got.trap, got.sine, got.ph);
          end
          mismatches++;
        end else begin
          want = pin_state_q.pop_front();
          if (got.ramp !== want.ramp || got.trap !== want.trap ||
              got.sine !== want.sine || got.ph !== want.ph) begin
            if (mismatches < 10) begin
              $display("mismatch: expected pins %b%b%b phase %0d, got pins %b%b%b phase %0d",
                       want.ramp, want.trap, want.sine, want.ph,
                       got.ramp, got.trap, got.sine, got.ph);
            end
            mismatches++;
          end
        end
      end
      out_if.ready <= !(gaps_on && $urandom_range(0, 99) < 22);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("pwm_envelope_sequencer_top_test NOT OK");
        $finish;
      end
    end
  end

  initial begin
    int k;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_RAMP_POINTS;
    cfg_data      = '0;
    pts        = 8'd10;
    sine_per   = 8'd32;
    sine_cnt   = 6'd20;
    plat_len   = 8'd100;
    slow_div   = 10'd100;
    cur_phase  = PH_TRI_UP;
    step_idx   = 8'd0;
    units_done = 8'd0;
    in_high    = 1'b0;
    ticks_left = 10'd0;
    pin_lvl    = 3'b000;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Settings out of reset: holds around a run of ticks
    queue_bits(1'b0, 2);
    queue_bits(1'b1, 6);
    queue_bits(1'b0, 1);

    // No unit anywhere in the cycle, zero divider: pins must hold
    wait_idle();
    set_all(0, 32, 0, 0, 0);
    queue_bits(1'b1, 3);
    queue_bits(1'b0, 1);

    // Single-point ramp, empty sine period, 32 sine steps
    wait_idle();
    set_all(1, 0, 32, 0, 1);
    queue_bits(1'b1, 6);

    // Sine period below the table peak: clamp the high count
    wait_idle();
    set_all(2, 4, 3, 1, 1);
    queue_bits(1'b1, 8);

    for (k = 0; k < 14; k++) begin
      wait_idle();
      gaps_on = (k != 5 && k != 6);
      case (k)
        8:  set_all(0, 1, 63, 0, 1);
        12: set_all(10, 32, 20, 100, 100);
        13: set_all(255, 255, 32, 255, 1023);
        default: begin
          set_all($urandom_range(0, 5),
                  $urandom_range(0, 1) ? $urandom_range(0, 12) : $urandom_range(28, 40),
                  ($urandom_range(0, 3) == 0) ? $urandom_range(18, 34) : $urandom_range(0, 5),
                  $urandom_range(0, 4),
                  $urandom_range(0, 3));
        end
      endcase
      queue_ticks(125, 12);
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("pwm_envelope_sequencer_top_test OK");
    end else begin
      $display("pwm_envelope_sequencer_top_test NOT OK");
    end
    $finish;
  end

endmodule
